// ===== design/tlsf_pkg.sv =====
// Package for the two-level segregated-fit class index: payload structs,
// command codes, default parameter values and bit-scan helpers.
// No dependencies.
`default_nettype none

package tlsf_pkg;

    localparam int SIZE_W  = 32;
    localparam int LEVEL_W = 5;

    // Defaults for the top-level parameters
    localparam int SUBCLASS_LOG_DEF   = 5;
    localparam int ALIGN_LOG_DEF      = 3;
    localparam int SIZE_LIMIT_LOG_DEF = 32;
    localparam int MIN_BLOCK_DEF      = 24;

    typedef enum logic [1:0] {
        CMD_FIND     = 2'd0,
        CMD_MARK_SET = 2'd1,
        CMD_MARK_CLR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]        command;
        logic [SIZE_W-1:0] size;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [LEVEL_W-1:0] first_level;
        logic [LEVEL_W-1:0] second_level;
        logic [SIZE_W-1:0]  adjusted_size;
    } t_out;

    // Mapped transaction held between the class mapper and the bitmap stage
    typedef struct packed {
        logic [1:0]         command;
        logic               hit;       // class exists (and request valid for find)
        logic [LEVEL_W-1:0] first_level;
        logic [LEVEL_W-1:0] second_level;
        logic [SIZE_W-1:0]  adjusted_size;
    } t_stage;

    // Highest set bit of a 33-bit value (0 for zero input)
    function automatic logic [5:0] high_bit33(input logic [32:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    // Lowest set bit of a 32-bit value (31 for zero input)
    function automatic logic [4:0] low_bit32(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd31;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/tlsf_map.sv =====
// Class mapper: size alignment, minimum, round-up and size-to-class mapping.
// Depends on tlsf_pkg.
`default_nettype none

module tlsf_map
    import tlsf_pkg::*;
#(
    parameter int SUBCLASS_LOG   = SUBCLASS_LOG_DEF,
    parameter int ALIGN_LOG      = ALIGN_LOG_DEF,
    parameter int SIZE_LIMIT_LOG = SIZE_LIMIT_LOG_DEF,
    parameter int MIN_BLOCK      = MIN_BLOCK_DEF
) (
    input  t_in    i_in,
    output t_stage o_stage
);

    localparam int CLASS_SHIFT = SUBCLASS_LOG + ALIGN_LOG;
    localparam int CLASS_COUNT = SIZE_LIMIT_LOG - CLASS_SHIFT + 1;

    localparam logic [32:0] SMALL_LIMIT = 33'(1) << CLASS_SHIFT;
    localparam logic [32:0] SUB_MASK    = (33'(1) << SUBCLASS_LOG) - 33'(1);
    localparam logic [32:0] ALIGN_MASK  = (33'(1) << ALIGN_LOG) - 33'(1);
    localparam logic [32:0] SIZE_LIMIT  = 33'(1) << SIZE_LIMIT_LOG;

    typedef struct packed {
        logic [5:0]         fl;
        logic [LEVEL_W-1:0] sl;
    } t_cls;

    function automatic t_cls map_cls(input logic [32:0] v);
        t_cls        c;
        logic [5:0]  f;
        logic [32:0] t;
        if (v < SMALL_LIMIT) begin
            c.fl = '0;
            c.sl = LEVEL_W'(v >> ALIGN_LOG);
        end else begin
            f    = high_bit33(v);
            t    = v >> (f - 6'(SUBCLASS_LOG));
            c.sl = LEVEL_W'(t & SUB_MASK);
            c.fl = f - 6'(CLASS_SHIFT - 1);
        end
        return c;
    endfunction

    logic [32:0]       aligned;
    logic              size_ok;
    logic [SIZE_W-1:0] adj;
    logic [32:0]       adj_ext;
    logic [32:0]       rounded;
    t_cls              find_cls;
    t_cls              mark_cls;

    assign aligned = ({1'b0, i_in.size} + ALIGN_MASK) & ~ALIGN_MASK;
    assign size_ok = (i_in.size != '0) && (aligned < SIZE_LIMIT);
    assign adj_ext = {1'b0, adj};

    always_comb begin
        adj = '0;
        if (size_ok) begin
            adj = (aligned[SIZE_W-1:0] > SIZE_W'(MIN_BLOCK)) ?
                  aligned[SIZE_W-1:0] : SIZE_W'(MIN_BLOCK);
        end
    end

    // Round up to the next subclass boundary for large requests
    always_comb begin
        rounded = adj_ext;
        if (adj_ext >= SMALL_LIMIT) begin
            rounded = adj_ext
                    + ((33'(1) << (high_bit33(adj_ext) - 6'(SUBCLASS_LOG))) - 33'(1));
        end
    end

    assign find_cls = map_cls(rounded);
    assign mark_cls = map_cls({1'b0, i_in.size});

    always_comb begin
        o_stage.command = i_in.command;
        o_stage.hit     = 1'b0;
        o_stage.first_level   = '0;
        o_stage.second_level  = '0;
        o_stage.adjusted_size = '0;
        case (i_in.command)
            CMD_FIND: begin
                o_stage.hit           = size_ok && (find_cls.fl < 6'(CLASS_COUNT));
                o_stage.first_level   = find_cls.fl[LEVEL_W-1:0];
                o_stage.second_level  = find_cls.sl;
                o_stage.adjusted_size = adj;
            end
            CMD_MARK_SET, CMD_MARK_CLR: begin
                o_stage.hit          = mark_cls.fl < 6'(CLASS_COUNT);
                o_stage.first_level  = mark_cls.fl[LEVEL_W-1:0];
                o_stage.second_level = mark_cls.sl;
            end
            default: begin
                o_stage.hit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/two_level_segregated_fit_index.sv =====
// Top level of the two-level segregated-fit class index: input stage,
// free-class bitmaps and result register. Depends on tlsf_pkg and tlsf_map.
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+------------------------
//   in      | input     | t_in    | i_in_valid / o_in_ready
//   out     | output    | t_out   | o_out_valid / i_out_ready
//
// Up to one transaction per cycle while the output is not stalled. A result
// passes through the stage 1 register and then the result register.
// Stage 1 maps the size to a class (align, minimum, round-up, bit scan) and
// registers it; stage 2 scans the bitmaps, writes them back on mark commands
// and registers the result. Bitmap updates land when the transaction moves
// into the result register, so the next transaction always sees them. Reset
// is synchronous and clears the valid flags and all bitmaps. A stalled output
// holds the result register, which in turn holds stage 1 once it is full.
`default_nettype none

module two_level_segregated_fit_index
    import tlsf_pkg::*;
#(
    parameter int SUBCLASS_LOG   = SUBCLASS_LOG_DEF,
    parameter int ALIGN_LOG      = ALIGN_LOG_DEF,
    parameter int SIZE_LIMIT_LOG = SIZE_LIMIT_LOG_DEF,
    parameter int MIN_BLOCK      = MIN_BLOCK_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int CLASS_SHIFT = SUBCLASS_LOG + ALIGN_LOG;
    localparam int CLASS_COUNT = SIZE_LIMIT_LOG - CLASS_SHIFT + 1;
    localparam int CLASS_W     = $clog2(CLASS_COUNT);
    localparam int SUB_COUNT   = 1 << SUBCLASS_LOG;

    // ---------------- stage 1: class mapping ----------------
    t_stage n_a;
    t_stage r_a;
    logic   r_a_valid;
    logic   adv;          // stage 2 takes the transaction in stage 1

    tlsf_map #(
        .SUBCLASS_LOG  (SUBCLASS_LOG),
        .ALIGN_LOG     (ALIGN_LOG),
        .SIZE_LIMIT_LOG(SIZE_LIMIT_LOG),
        .MIN_BLOCK     (MIN_BLOCK)
    ) u_map (
        .i_in   (i_in),
        .o_stage(n_a)
    );

    assign adv        = r_a_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || adv;

    // ---------------- stage 2: bitmaps ----------------
    logic [CLASS_COUNT-1:0]  r_fl_map;
    logic [SUB_COUNT-1:0]    r_sl_map [CLASS_COUNT];
    // lowest nonempty subclass per class; meaningful only while the
    // class's first-level bit is set
    logic [SUBCLASS_LOG-1:0] r_low    [CLASS_COUNT];

    logic [CLASS_W-1:0]      idx;
    logic [SUBCLASS_LOG-1:0] sl_idx;
    logic [SUB_COUNT-1:0]    row_rd;
    logic [SUB_COUNT-1:0]    row_hi;
    logic [SUB_COUNT-1:0]    bit_mask;
    logic [SUB_COUNT-1:0]    new_row;
    logic [LEVEL_W-1:0]      new_low;
    logic [CLASS_COUNT-1:0]  upper;
    logic [LEVEL_W-1:0]      up_f;
    logic [CLASS_W-1:0]      up_idx;
    logic                    do_mark;
    logic                    n_fl_bit;
    t_out                    n_out;
    t_out                    r_out;
    logic                    r_out_valid;

    assign idx      = r_a.first_level[CLASS_W-1:0];
    assign sl_idx   = r_a.second_level[SUBCLASS_LOG-1:0];
    assign row_rd   = r_sl_map[idx];
    assign bit_mask = SUB_COUNT'(1) << sl_idx;
    assign row_hi   = row_rd & ({SUB_COUNT{1'b1}} << sl_idx);
    // classes strictly above the requested one
    assign upper    = r_fl_map & ({CLASS_COUNT{1'b1}} << (6'(r_a.first_level) + 6'd1));
    assign up_f     = low_bit32(32'(upper));
    assign up_idx   = up_f[CLASS_W-1:0];

    assign new_row  = (r_a.command == CMD_MARK_SET) ? (row_rd | bit_mask)
                                                    : (row_rd & ~bit_mask);
    assign new_low  = low_bit32(32'(new_row));
    assign do_mark  = adv && r_a.hit &&
                      ((r_a.command == CMD_MARK_SET) || (r_a.command == CMD_MARK_CLR));
    // set on mark-nonempty; drop on mark-empty only when the row runs dry
    assign n_fl_bit = (r_a.command == CMD_MARK_SET) ? 1'b1
                    : ((new_row == '0) ? 1'b0 : r_fl_map[idx]);

    always_comb begin
        n_out = '0;
        case (r_a.command)
            CMD_FIND: begin
                n_out.adjusted_size = r_a.adjusted_size;
                if (r_a.hit) begin
                    if (row_hi != '0) begin
                        n_out.found        = 1'b1;
                        n_out.first_level  = r_a.first_level;
                        n_out.second_level = low_bit32(32'(row_hi));
                    end else if (upper != '0) begin
                        n_out.found        = 1'b1;
                        n_out.first_level  = up_f;
                        n_out.second_level = LEVEL_W'(r_low[up_idx]);
                    end
                end
            end
            CMD_MARK_SET, CMD_MARK_CLR: begin
                n_out.found        = r_a.hit;
                n_out.first_level  = r_a.first_level;
                n_out.second_level = r_a.second_level;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Control state: valid flags and bitmaps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fl_map    <= '0;
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_sl_map[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (do_mark) begin
                r_sl_map[idx] <= new_row;
                r_fl_map[idx] <= n_fl_bit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a <= n_a;
        end
        if (adv) begin
            r_out <= n_out;
        end
        if (do_mark) begin
            r_low[idx] <= new_low[SUBCLASS_LOG-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== design/tlsf_checker.sv =====
// Port-level checker for two_level_segregated_fit_index, with its bind.
// Depends on tlsf_pkg.
`default_nettype none

module tlsf_checker
    import tlsf_pkg::*;
#(
    parameter int CLASS_COUNT = SIZE_LIMIT_LOG_DEF - SUBCLASS_LOG_DEF - ALIGN_LOG_DEF + 1,
    parameter int MIN_BLOCK   = MIN_BLOCK_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // Result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A reported class always exists
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.found |-> o_out.first_level < LEVEL_W'(CLASS_COUNT))
        else $error("found class out of range");

    // A nonzero adjusted size honors the minimum block
    a_adj_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.adjusted_size != '0) |->
            o_out.adjusted_size >= SIZE_W'(MIN_BLOCK))
        else $error("adjusted size below minimum");

endmodule

bind two_level_segregated_fit_index tlsf_checker #(
    .CLASS_COUNT(CLASS_COUNT),
    .MIN_BLOCK  (MIN_BLOCK)
) u_tlsf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);

`default_nettype wire
